// ===== rtl/core/lr_pkg.sv =====
// Shared types, widths and codes for the line rasterizer.
`default_nettype none

package lr_pkg;

  localparam int CoordBits = 10;
  localparam int ErrBits   = CoordBits + 2;
  localparam int LeftBits  = CoordBits + 1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [ErrBits-1:0]   err_t;
  typedef logic [LeftBits-1:0]  left_t;
  typedef logic [1:0]           dir_t;

  // 2-bit two's complement step directions
  localparam dir_t DirZero = 2'd0;
  localparam dir_t DirPos  = 2'd1;
  localparam dir_t DirNeg  = 2'd3;

  localparam logic ModeStart = 1'b0;
  localparam logic ModeStep  = 1'b1;

  typedef struct packed {
    logic   mode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } item_t;

  typedef struct packed {
    coord_t cur_col;
    coord_t cur_row;
    err_t   col_error;
    err_t   row_error;
    coord_t abs_dx;
    coord_t abs_dy;
    coord_t major_len;
    dir_t   col_dir;
    dir_t   row_dir;
    left_t  points_left;
    logic   busy;
  } state_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   point_valid;
    logic   last_point;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lr_step.sv =====
// Combinational DDA step: current state plus one item gives next state and at most one point.
`default_nettype none

module lr_step (
  input  lr_pkg::item_t   item_i,
  input  lr_pkg::state_t  state_i,
  output lr_pkg::state_t  state_o,
  output lr_pkg::result_t result_o
);

  function automatic lr_pkg::coord_t move(input lr_pkg::coord_t pos, input lr_pkg::dir_t dir);
    lr_pkg::coord_t res;
    res = pos;
    if (dir == lr_pkg::DirPos) begin
      res = pos + lr_pkg::CoordBits'(1);
    end else if (dir == lr_pkg::DirNeg) begin
      res = pos - lr_pkg::CoordBits'(1);
    end
    return res;
  endfunction

  lr_pkg::state_t base;
  lr_pkg::coord_t dx_mag, dy_mag, major;
  lr_pkg::dir_t   cdir, rdir;
  lr_pkg::err_t   col_sum, row_sum, major_ext;
  lr_pkg::left_t  left_dec;
  logic           emit;

  always_comb begin
    // deltas and directions of a new line
    if (item_i.end_x > item_i.start_x) begin
      dx_mag = item_i.end_x - item_i.start_x;
      cdir   = lr_pkg::DirPos;
    end else if (item_i.end_x < item_i.start_x) begin
      dx_mag = item_i.start_x - item_i.end_x;
      cdir   = lr_pkg::DirNeg;
    end else begin
      dx_mag = '0;
      cdir   = lr_pkg::DirZero;
    end
    if (item_i.end_y > item_i.start_y) begin
      dy_mag = item_i.end_y - item_i.start_y;
      rdir   = lr_pkg::DirPos;
    end else if (item_i.end_y < item_i.start_y) begin
      dy_mag = item_i.start_y - item_i.end_y;
      rdir   = lr_pkg::DirNeg;
    end else begin
      dy_mag = '0;
      rdir   = lr_pkg::DirZero;
    end
    major = (dx_mag > dy_mag) ? dx_mag : dy_mag;

    base = state_i;
    if (item_i.mode == lr_pkg::ModeStart) begin
      base.cur_col     = item_i.start_x;
      base.cur_row     = item_i.start_y;
      base.col_error   = '0;
      base.row_error   = '0;
      base.abs_dx      = dx_mag;
      base.abs_dy      = dy_mag;
      base.major_len   = major;
      base.col_dir     = cdir;
      base.row_dir     = rdir;
      base.points_left = lr_pkg::LeftBits'(major) + lr_pkg::LeftBits'(2);
      base.busy        = 1'b1;
    end

    emit = (item_i.mode == lr_pkg::ModeStart) || state_i.busy;

    left_dec  = base.points_left - lr_pkg::LeftBits'(1);
    major_ext = lr_pkg::ErrBits'(base.major_len);
    col_sum   = base.col_error + lr_pkg::ErrBits'(base.abs_dx);
    row_sum   = base.row_error + lr_pkg::ErrBits'(base.abs_dy);

    result_o = '0;
    state_o  = state_i;
    if (emit) begin
      result_o.point_x     = base.cur_col;
      result_o.point_y     = base.cur_row;
      result_o.point_valid = 1'b1;
      result_o.last_point  = (left_dec == '0);

      state_o             = base;
      state_o.points_left = left_dec;
      state_o.busy        = (left_dec != '0);
      state_o.col_error   = col_sum;
      state_o.row_error   = row_sum;
      if (col_sum > major_ext) begin
        state_o.col_error = col_sum - major_ext;
        state_o.cur_col   = move(base.cur_col, base.col_dir);
      end
      if (row_sum > major_ext) begin
        state_o.row_error = row_sum - major_ext;
        state_o.cur_row   = move(base.cur_row, base.row_dir);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lr_result_queue.sv =====
// Two-entry result queue that decouples the step logic from output stall.
`default_nettype none

module lr_result_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lr_pkg::result_t data_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lr_pkg::result_t data_o
);

  lr_pkg::result_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  // a full queue still takes a transaction in the cycle it drains one
  assign room_o      = (count_q != 2'd2) || pop;
  assign data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/line_rasterizer.sv =====
// Line rasterizer top level: input register, DDA state and step logic, result queue.
// An accepted item is held in the input register until the result queue has room,
// then its point is written into the queue, which offers it on the output.
// Throughput: one item per cycle while the result queue has room, set by the combinational state update in lr_step.
// The two-entry result queue keeps input flowing while the output is stalled, until it fills.
// Reset (rst_ni low, asynchronous) empties both stages and clears the line state
// to idle with all coordinates, errors and counts at zero.
`default_nettype none

module line_rasterizer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [lr_pkg::CoordBits-1:0] start_x_i,
  input  logic [lr_pkg::CoordBits-1:0] start_y_i,
  input  logic [lr_pkg::CoordBits-1:0] end_x_i,
  input  logic [lr_pkg::CoordBits-1:0] end_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lr_pkg::CoordBits-1:0] point_x_o,
  output logic [lr_pkg::CoordBits-1:0] point_y_o,
  output logic                       point_valid_o,
  output logic                       last_point_o
);

  lr_pkg::item_t   item_q, item_d;
  logic            item_valid_q, item_valid_d;
  lr_pkg::state_t  state_q, state_d, state_next;
  lr_pkg::result_t step_result, out_result;
  logic            room, fire, in_take;

  assign fire       = item_valid_q && room;
  assign in_stall_o = item_valid_q && !room;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    item_d       = item_q;
    if (in_take) begin
      item_valid_d   = 1'b1;
      item_d.mode    = mode_i;
      item_d.start_x = start_x_i;
      item_d.start_y = start_y_i;
      item_d.end_x   = end_x_i;
      item_d.end_y   = end_y_i;
    end else if (fire) begin
      item_valid_d = 1'b0;
    end
    state_d = fire ? state_next : state_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      state_q      <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      state_q      <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  lr_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .state_o  (state_next),
    .result_o (step_result)
  );

  lr_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire),
    .data_i      (step_result),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign point_x_o     = out_result.point_x;
  assign point_y_o     = out_result.point_y;
  assign point_valid_o = out_result.point_valid;
  assign last_point_o  = out_result.last_point;

endmodule

`default_nettype wire

// ===== rtl/core/lr_checker.sv =====
// Port-level assertions for the line rasterizer and their bind.
`default_nettype none

module lr_sva (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_stall_i,
  input logic [lr_pkg::CoordBits-1:0] point_x_i,
  input logic [lr_pkg::CoordBits-1:0] point_y_i,
  input logic                         point_valid_i,
  input logic                         last_point_i
);

  // a stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(point_x_i) && $stable(point_y_i)
      && $stable(point_valid_i) && $stable(last_point_i))
    else $error("output payload changed while stalled");

  // idle step result carries all-zero fields
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !point_valid_i |-> point_x_i == '0 && point_y_i == '0 && !last_point_i)
    else $error("invalid point with nonzero fields");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_point_i |-> point_valid_i)
    else $error("last flag on an invalid point");

endmodule

bind line_rasterizer lr_sva u_lr_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .point_x_i     (point_x_o),
  .point_y_i     (point_y_o),
  .point_valid_i (point_valid_o),
  .last_point_i  (last_point_o)
);

`default_nettype wire

// ===== dv/lr_checker.sv =====
// Line rasterizer checker: watches both channels, predicts each point and compares.
module lr_checker
  import lr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_stall_i,
  input  logic   mode_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  input  logic   out_valid_i,
  input  logic   out_stall_i,
  input  coord_t point_x_i,
  input  coord_t point_y_i,
  input  logic   point_valid_i,
  input  logic   last_point_i,
  output int     fail_count_o,
  output int     pending_o,
  output int     checked_o
);

  // Predicted walker state
  coord_t pos_x, pos_y;
  err_t   err_x, err_y;
  coord_t span_x, span_y, span_major;
  dir_t   step_x, step_y;
  left_t  remaining;
  logic   drawing;

  result_t point_q[$];
  item_t   req;
  result_t want;
  int      fails;
  int      checked;

  function automatic dir_t heading(input coord_t a, input coord_t b, output coord_t mag);
    if (b > a) begin
      mag = b - a;
      return DirPos;
    end
    if (b < a) begin
      mag = a - b;
      return DirNeg;
    end
    mag = '0;
    return DirZero;
  endfunction

  function automatic coord_t nudge(input coord_t p, input dir_t d);
    case (d)
      DirPos:  return p + coord_t'(1);
      DirNeg:  return p - coord_t'(1);
      default: return p;
    endcase
  endfunction

  // Point emitted for one transaction; updates the walker state.
  function automatic result_t trace_point(input item_t it);
    result_t r;
    r = '0;
    if (it.mode == ModeStart) begin
      step_x     = heading(it.start_x, it.end_x, span_x);
      step_y     = heading(it.start_y, it.end_y, span_y);
      span_major = (span_x > span_y) ? span_x : span_y;
      pos_x      = it.start_x;
      pos_y      = it.start_y;
      err_x      = '0;
      err_y      = '0;
      remaining  = left_t'(span_major) + left_t'(2);
      drawing    = 1'b1;
    end else if (!drawing) begin
      return r;
    end
    r.point_x     = pos_x;
    r.point_y     = pos_y;
    r.point_valid = 1'b1;
    remaining = remaining - left_t'(1);
    if (remaining == '0) begin
      r.last_point = 1'b1;
      drawing      = 1'b0;
    end
    err_x = err_x + err_t'(span_x);
    err_y = err_y + err_t'(span_y);
    if (err_x > err_t'(span_major)) begin
      err_x = err_x - err_t'(span_major);
      pos_x = nudge(pos_x, step_x);
    end
    if (err_y > err_t'(span_major)) begin
      err_y = err_y - err_t'(span_major);
      pos_y = nudge(pos_y, step_y);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x      = '0;
      pos_y      = '0;
      err_x      = '0;
      err_y      = '0;
      span_x     = '0;
      span_y     = '0;
      span_major = '0;
      step_x     = DirZero;
      step_y     = DirZero;
      remaining  = '0;
      drawing    = 1'b0;
      point_q.delete();
      fails   = 0;
      checked = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        req.mode    = mode_i;
        req.start_x = start_x_i;
        req.start_y = start_y_i;
        req.end_x   = end_x_i;
        req.end_y   = end_y_i;
        point_q.push_back(trace_point(req));
      end
      if (out_valid_i && !out_stall_i) begin
        if (point_q.size() == 0) begin
          $display("%0t: unexpected point (%0d,%0d) valid=%0b last=%0b, nothing expected",
                   $time, point_x_i, point_y_i, point_valid_i, last_point_i);
          fails++;
        end else begin
          want = point_q.pop_front();
          check_field("point_x", 32'(want.point_x), 32'(point_x_i));
          check_field("point_y", 32'(want.point_y), 32'(point_y_i));
          check_field("point_valid", 32'(want.point_valid), 32'(point_valid_i));
          check_field("last_point", 32'(want.last_point), 32'(last_point_i));
          checked++;
        end
      end
      fail_count_o <= fails;
      pending_o    <= point_q.size();
      checked_o    <= checked;
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the line rasterizer: clock, reset, stimulus and verdict.
module tb;
  import lr_pkg::*;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   mode;
  coord_t start_x, start_y, end_x, end_y;
  logic   out_valid;
  logic   out_stall;
  coord_t point_x, point_y;
  logic   point_valid;
  logic   last_point;

  int fail_count;
  int pending;
  int checked;
  int n_items;
  int n_lines;
  bit idling;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  line_rasterizer dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .start_x_i     (start_x),
    .start_y_i     (start_y),
    .end_x_i       (end_x),
    .end_y_i       (end_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .point_valid_o (point_valid),
    .last_point_o  (last_point)
  );

  lr_checker point_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .mode_i        (mode),
    .start_x_i     (start_x),
    .start_y_i     (start_y),
    .end_x_i       (end_x),
    .end_y_i       (end_y),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .point_valid_i (point_valid),
    .last_point_i  (last_point),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // Entered and left at a falling edge.
  task automatic push_item(input logic m, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    @(negedge clk);
  endtask

  task automatic start_line(input coord_t sx, input coord_t sy,
                            input coord_t ex, input coord_t ey);
    push_item(ModeStart, sx, sy, ex, ey);
    n_lines++;
  endtask

  // Endpoint fields carry noise on step transactions.
  task automatic step_points(input int n);
    repeat (n) begin
      push_item(ModeStep, coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom));
    end
  endtask

  function automatic coord_t near(input coord_t c, input int reach);
    int v;
    v = int'(c) + $urandom_range(0, 2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return coord_t'(v);
  endfunction

  task automatic random_line();
    coord_t sx, sy, ex, ey;
    int kind, reach, major, steps, pick;
    kind = $urandom_range(0, 99);
    sx = coord_t'($urandom);
    sy = coord_t'($urandom);
    // pull some lines against the border
    if ($urandom_range(0, 5) == 0) sx = $urandom_range(0, 1) ? '0 : '1;
    if ($urandom_range(0, 5) == 0) sy = $urandom_range(0, 1) ? '0 : '1;
    reach = (kind < 75) ? 12 : (kind < 85) ? 120 : 1023;
    ex = near(sx, reach);
    ey = near(sy, reach);
    major = (ex > sx) ? int'(ex - sx) : int'(sx - ex);
    if (((ey > sy) ? int'(ey - sy) : int'(sy - ey)) > major) begin
      major = (ey > sy) ? int'(ey - sy) : int'(sy - ey);
    end
    pick = $urandom_range(0, 9);
    if (kind >= 85) steps = $urandom_range(0, 20);          // long line, cut short
    else if (pick < 7) steps = major + 1;                   // run to the end
    else if (pick < 8) steps = $urandom_range(0, major);    // abandoned by next start
    else steps = major + 1 + $urandom_range(1, 3);          // trailing steps while idle
    start_line(sx, sy, ex, ey);
    step_points(steps);
  endtask

  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    mode     = ModeStep;
    start_x  = '0;
    start_y  = '0;
    end_x    = '0;
    end_y    = '0;
    n_items  = 0;
    n_lines  = 0;
    idling   = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle step, zero length, corner diagonals, restarts, axis lines
    step_points(1);
    start_line(7, 7, 7, 7);
    step_points(2);
    start_line(0, 0, 1023, 1023);
    step_points(3);
    start_line(1023, 1023, 0, 0);
    step_points(2);
    start_line(1023, 0, 0, 1023);
    step_points(1);
    start_line(10, 20, 13, 20);
    step_points(5);
    start_line(30, 40, 30, 36);
    step_points(6);

    while (n_items < 500) begin
      idling = (n_items < 420) && ($urandom_range(0, 3) != 0);
      random_line();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Summary: %0d lines started over %0d transactions, %0d points compared",
             n_lines, n_items, checked);
    $display("Random bursts of input gaps and output stalls, last stretch at full rate");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/lr_pkg.sv
rtl/core/lr_step.sv
rtl/core/lr_result_queue.sv
rtl/core/line_rasterizer.sv
rtl/core/lr_checker.sv
dv/lr_checker.sv
dv/tb.sv
